// ===== rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Character codes, result type and helper functions for the script tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	// keyword_progress codes
	localparam logic [2:0] KW_NONE     = 3'd0;
	localparam logic [2:0] KW_MATCHED  = 3'd4;
	localparam logic [2:0] KW_MISMATCH = 3'd5;

	localparam logic KIND_NAME = 1'b0;
	localparam logic KIND_PATH = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
		logic       last;
	} res_t;

	function automatic logic is_alnum(input logic [7:0] c);
		is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// letters of "path"
	function automatic logic [7:0] kw_char(input logic [1:0] idx);
		case (idx)
			2'd0:    kw_char = 8'h70;
			2'd1:    kw_char = 8'h61;
			2'd2:    kw_char = 8'h74;
			default: kw_char = 8'h68;
		endcase
	endfunction

endpackage

// ===== rtl/script_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// script_line_tokenizer
// Streams the characters of names and of path directives out of script text.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one character (ch) or an end-of-line
// marker (end_of_line). The parser updates its state in the cycle a request is
// accepted and writes zero, one or two result requests into a four-entry
// output queue. Output channel: out_valid/out_stall carry kind, out_char and
// last, one result per transfer.
// A result is registered into the output queue when its character is accepted.
// Throughput: one character per cycle while the queue has two free entries;
// each character yields at most two results and most yield one or none, so
// the output port, draining one result a cycle, sets the sustained rate.
// When the receiver stalls, the queue fills and in_stall rises once fewer
// than two entries are free; nothing is dropped.
// Reset (arst_n low): the queue empties and the parser returns to line start.
// No clearing pass; the block takes characters as soon as reset is released.
// ----------------------------------------------------------------------------
module script_line_tokenizer #(
	parameter int MAX_LINE = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] out_char,
	output logic       last
);
	import slt_pkg::*;

	localparam int POS_W = $clog2(MAX_LINE + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

	typedef enum logic [3:0] {
		MODE_START, MODE_NAME, MODE_META_WAIT, MODE_META, MODE_PARAM_WAIT,
		MODE_EQ_WAIT, MODE_BARE, MODE_QUOTED, MODE_IGNORE
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [7:0]       held_q, held_d;
	logic             hv_q, hv_d;
	logic [2:0]       kw_q, kw_d;
	logic [POS_W-1:0] pos_q, pos_d;

	logic in_acc;
	logic do_push, do_term, do_finish;
	logic push_kind;
	logic e0_v, e1_v;
	res_t e0, e1;

	assign in_acc = in_valid && !in_stall;

	always_comb begin
		mode_d    = mode_q;
		held_d    = held_q;
		hv_d      = hv_q;
		kw_d      = kw_q;
		pos_d     = pos_q;
		do_push   = 1'b0;
		do_term   = 1'b0;
		do_finish = 1'b0;
		push_kind = KIND_NAME;
		e0_v      = 1'b0;
		e1_v      = 1'b0;
		e0        = '0;
		e1        = '0;

		if (end_of_line) begin
			do_term = 1'b1;
		end else if (mode_q == MODE_IGNORE) begin
			// rest of line dropped
		end else if (ch == CH_NUL || pos_q >= POS_MAX) begin
			do_term = 1'b1;
		end else begin
			pos_d = pos_q + 1'b1;
			unique case (mode_q)
				MODE_START: begin
					if (ch == CH_SPACE || ch == CH_TAB) begin
					end else if (is_alnum(ch)) begin
						mode_d = MODE_NAME;
						held_d = ch;
						hv_d   = 1'b1;
					end else if (ch == CH_HASH) begin
						mode_d = MODE_META_WAIT;
						kw_d   = KW_NONE;
						hv_d   = 1'b0;
					end else begin
						mode_d = MODE_IGNORE;
					end
				end
				MODE_NAME: begin
					if (is_alnum(ch) || ch == CH_DASH || ch == CH_UNDER) begin
						do_push = 1'b1;
					end else begin
						do_term = 1'b1;
					end
				end
				MODE_META_WAIT: begin
					if (is_space(ch)) begin
					end else if (is_alnum(ch)) begin
						kw_d   = (ch == kw_char(2'd0)) ? 3'd1 : KW_MISMATCH;
						mode_d = MODE_META;
					end else begin
						mode_d = MODE_IGNORE;
					end
				end
				MODE_META: begin
					if (is_alnum(ch)) begin
						if (kw_q < KW_MATCHED && ch == kw_char(kw_q[1:0])) begin
							kw_d = kw_q + 3'd1;
						end else begin
							kw_d = KW_MISMATCH;
						end
					end else if (is_space(ch)) begin
						mode_d = MODE_PARAM_WAIT;
					end else if (ch == CH_EQ) begin
						mode_d = MODE_EQ_WAIT;
					end else begin
						mode_d = MODE_IGNORE;
					end
				end
				MODE_PARAM_WAIT, MODE_EQ_WAIT: begin
					if (is_space(ch)) begin
					end else if (ch == CH_EQ && mode_q == MODE_PARAM_WAIT) begin
					end else if (ch == CH_QUOTE) begin
						mode_d = MODE_QUOTED;
					end else begin
						mode_d    = MODE_BARE;
						do_push   = (kw_q == KW_MATCHED);
						push_kind = KIND_PATH;
					end
				end
				MODE_BARE: begin
					if (ch == CH_SPACE || ch == CH_TAB) begin
						do_finish = 1'b1;
					end else begin
						do_push   = (kw_q == KW_MATCHED);
						push_kind = KIND_PATH;
					end
				end
				MODE_QUOTED: begin
					if (ch == CH_QUOTE) begin
						do_finish = 1'b1;
					end else begin
						do_push   = (kw_q == KW_MATCHED);
						push_kind = KIND_PATH;
					end
				end
				default: mode_d = MODE_IGNORE;
			endcase
		end

		// held character goes out, new one takes its place
		if (do_push) begin
			e0_v   = hv_q;
			e0     = '{kind: push_kind, ch: held_q, last: 1'b0};
			held_d = ch;
			hv_d   = 1'b1;
		end

		if (do_term) begin
			mode_d = MODE_IGNORE;
			if (mode_q == MODE_NAME) begin
				e0_v   = hv_q;
				e0     = '{kind: KIND_NAME, ch: held_q, last: 1'b1};
				hv_d   = 1'b0;
				held_d = CH_NUL;
			end else if (mode_q == MODE_BARE || mode_q == MODE_QUOTED) begin
				do_finish = 1'b1;
			end
		end

		if (do_finish) begin
			mode_d = MODE_IGNORE;
			hv_d   = 1'b0;
			held_d = CH_NUL;
			if (kw_q == KW_MATCHED) begin
				if (hv_q && held_q == CH_BSLASH) begin
					e0_v = 1'b1;
					e0   = '{kind: KIND_PATH, ch: held_q, last: 1'b1};
				end else if (hv_q) begin
					e0_v = 1'b1;
					e0   = '{kind: KIND_PATH, ch: held_q, last: 1'b0};
					e1_v = 1'b1;
					e1   = '{kind: KIND_PATH, ch: CH_BSLASH, last: 1'b1};
				end else begin
					e0_v = 1'b1;
					e0   = '{kind: KIND_PATH, ch: CH_BSLASH, last: 1'b1};
				end
			end
		end

		// end of line: back to line start
		if (end_of_line) begin
			mode_d = MODE_START;
			held_d = CH_NUL;
			hv_d   = 1'b0;
			kw_d   = KW_NONE;
			pos_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			held_q <= CH_NUL;
			hv_q   <= 1'b0;
			kw_q   <= KW_NONE;
			pos_q  <= '0;
		end else if (in_acc) begin
			mode_q <= mode_d;
			held_q <= held_d;
			hv_q   <= hv_d;
			kw_q   <= kw_d;
			pos_q  <= pos_d;
		end
	end

	// output queue, four entries, up to two writes and one read a cycle
	res_t       q_mem [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	logic       out_acc;
	logic [1:0] n_wr;
	res_t       w0, w1;
	logic       w0_v, w1_v;

	assign out_acc   = out_valid && !out_stall;
	assign out_valid = (cnt_q != 3'd0);
	assign in_stall  = (cnt_q > 3'd2);

	// pack e1 down when e0 is empty (the parser sets e1 only together with e0)
	always_comb begin
		w0_v = in_acc && (e0_v || e1_v);
		w1_v = in_acc && e0_v && e1_v;
		w0   = e0_v ? e0 : e1;
		w1   = e1;
		n_wr = {1'b0, w0_v} + {1'b0, w1_v};
	end

	always_ff @(posedge clk) begin
		if (w0_v) q_mem[wr_ptr_q] <= w0;
		if (w1_v) q_mem[wr_ptr_q + 2'd1] <= w1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_wr;
			if (out_acc) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, n_wr} - {2'b0, out_acc};
		end
	end

	assign kind     = q_mem[rd_ptr_q].kind;
	assign out_char = q_mem[rd_ptr_q].ch;
	assign last     = q_mem[rd_ptr_q].last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("output queue overflow");

	a_held_mode: assert property (@(posedge clk) disable iff (!arst_n)
		hv_q |-> (mode_q == MODE_NAME || mode_q == MODE_BARE || mode_q == MODE_QUOTED))
		else $error("held character outside a token");

	a_eol_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && end_of_line) |=> (mode_q == MODE_START && pos_q == '0 && !hv_q))
		else $error("end of line did not restart parser");

	a_kw_range: assert property (@(posedge clk) disable iff (!arst_n)
		kw_q <= KW_MISMATCH)
		else $error("keyword progress out of range");

endmodule
